// ===== src/spio_pkg.sv =====
// ----------------------------------------------------------------------------
// spio_pkg
// Shared types, codes and constants of the serial and parallel I/O controller.
// ----------------------------------------------------------------------------
package spio_pkg;

  localparam int TX_FIFO_DEPTH_DEF = 16;

  // numerator width of the timing division: 26-bit clock * 23-bit factor
  localparam int NUM_W = 49;
  localparam int HZ_W  = 26;
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] MAX48 = {TIME_W{1'b1}};
  localparam logic [6:0] MAX_CHARS = 7'd64;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] REG_SDATA = 2'd0;
  localparam logic [1:0] REG_PDATA = 2'd1;
  localparam logic [1:0] REG_STAT  = 2'd2;
  localparam logic [1:0] REG_CTRL  = 2'd3;

  localparam logic [1:0] CFG_LINK   = 2'd0;
  localparam logic [1:0] CFG_TSTATE = 2'd1;
  localparam logic [1:0] CFG_XCLK   = 2'd2;

  // parallel port sub-commands of a mode write
  localparam logic [2:0] PCMD_PRIM_SET = 3'd4;
  localparam logic [2:0] PCMD_PRIM_CLR = 3'd5;
  localparam logic [2:0] PCMD_XBUSY_CLR = 3'd6;

  // control flag bit positions
  localparam int CF_TXEN  = 0;
  localparam int CF_DTR   = 1;
  localparam int CF_RXEN  = 2;
  localparam int CF_SBRK  = 3;
  localparam int CF_RTS   = 4;
  localparam int CF_IM1   = 5;
  localparam int CF_IM2   = 6;
  localparam int CF_PRIM  = 7;
  localparam int CF_XBUSY = 8;
  localparam int CF_INTP0 = 9;
  localparam int CF_INTP1 = 10;
  localparam int CF_LBUSY = 11;
  localparam int CF_HELD  = 12;
  localparam int CF_TXRDY = 13;
  localparam int CF_TXEMP = 14;

  // error flag bit positions
  localparam int EF_PE    = 0;
  localparam int EF_OE    = 1;
  localparam int EF_FE    = 2;
  localparam int EF_BRK   = 3;
  localparam int EF_RXRDY = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] elapsed_tstates;
    logic        sub_busy;
    logic        sub_acked;
    logic        peer_cts;
    logic        peer_dsr;
    logic        peer_dcd;
    logic        peer_ri;
    logic        rx_offered;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
    logic        strobe_valid;
    logic [7:0]  strobe_byte;
    logic [15:0] strobe_delay;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic        dtr_line;
    logic        rts_line;
    logic        ring_line;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_start;
    logic div_commit;
    logic tick_add;
    logic tick_cap;
    logic iter;
    logic emit;
    logic emit_iter;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] reg_addr;
    logic       held;
    logic       param_calc;
    logic       link;
    logic       ct_nonzero;
    logic       div_busy;
    logic       more;
    logic       out_free;
  } stat_t;

endpackage

// ===== src/spio_ram.sv =====
// ----------------------------------------------------------------------------
// spio_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spio_div.sv =====
// ----------------------------------------------------------------------------
// spio_div
// Restoring divider, one quotient bit per cycle; a zero divisor counts as one.
// ----------------------------------------------------------------------------
module spio_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spio_pkg::NUM_W-1:0] num,
  input  logic [spio_pkg::HZ_W-1:0]  den,
  output logic                       busy,
  output logic [spio_pkg::NUM_W-1:0] quo
);
  import spio_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [HZ_W-1:0]  rem;
  logic [HZ_W-1:0]  dvs;
  logic [CNT_W-1:0] cnt;
  logic [HZ_W:0]    trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      rem  <= '0;
      quo  <= num;
      dvs  <= (den == '0) ? HZ_W'(1) : den;
    end else if (busy) begin
      rem <= fits ? HZ_W'(trial - {1'b0, dvs}) : trial[HZ_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== src/spio_ctrl.sv =====
// ----------------------------------------------------------------------------
// spio_ctrl
// Sequencer: steps each item through execute, then timing math or the tick loop, and result output.
// ----------------------------------------------------------------------------
module spio_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spio_pkg::stat_t stat,
  output spio_pkg::cmd_t  cmd
);
  import spio_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MUL1, S_MUL2, S_MUL3, S_DIV_GO, S_DIV_WAIT,
    S_OUT, S_TICK_ADD, S_TICK_CAP, S_LOOP_CHK, S_LOOP_OUT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_OUT;
        if (stat.func == FUNC_WRITE && !stat.held) begin
          if (stat.reg_addr == REG_PDATA ||
              (stat.reg_addr == REG_STAT && stat.param_calc)) begin
            state_next = S_MUL1;
          end
        end else if (stat.func == FUNC_TICK && stat.link && stat.ct_nonzero) begin
          state_next = S_TICK_ADD;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          cmd.div_commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK_ADD: begin
        cmd.tick_add = 1'b1;
        state_next = S_TICK_CAP;
      end
      S_TICK_CAP: begin
        cmd.tick_cap = 1'b1;
        state_next = S_LOOP_CHK;
      end
      S_LOOP_CHK: begin
        if (stat.more) begin
          cmd.iter = 1'b1;
          state_next = S_LOOP_OUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_LOOP_OUT: begin
        if (stat.out_free) begin
          cmd.emit_iter = 1'b1;
          state_next = stat.more ? S_LOOP_CHK : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !stat.div_busy)
    else $error("divider busy while idle");
  a_commit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_commit |-> $past(state == S_DIV_GO) || $past(state == S_DIV_WAIT))
    else $error("commit without division");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.emit_iter))
    else $error("two emits at once");

endmodule

// ===== src/spio_dp.sv =====
// ----------------------------------------------------------------------------
// spio_dp
// Datapath: registers, flags, transmit FIFO, timing math and result register.
// ----------------------------------------------------------------------------
module spio_dp #(
  parameter int DEPTH = spio_pkg::TX_FIFO_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  spio_pkg::cmd_t            cmd,
  output spio_pkg::stat_t           stat,
  input  spio_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spio_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  input  logic [1:0]                cfg_index,
  input  logic [spio_pkg::HZ_W-1:0] cfg_data
);
  import spio_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  in_item_t        item;
  logic            link;
  logic [HZ_W-1:0] tstate_hz;
  logic [HZ_W-1:0] xclk_hz;
  logic [7:0]      pb [8];
  logic [2:0]      pptr;
  logic [14:0]     cf;
  logic [7:0]      smode;
  logic [4:0]      ef;
  logic [7:0]      rlatch;
  logic [7:0]      pout;
  logic [3:0]      plines;
  logic [CW-1:0]   count;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [TIME_W-1:0] accum;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] ctime;
  logic [6:0]      nchar;
  logic            mode_char;
  logic [16:0]     ma;
  logic [19:0]     mb;
  logic [NUM_W-1:0] mp;
  logic [16:0]     prod1;
  logic [19:0]     prod2;
  logic [45:0]     prod3;
  logic [15:0]     sdelay;
  logic            strobe_q;
  logic [7:0]      rd_q;
  logic            it_txv;
  logic [7:0]      it_txb;
  logic            it_taken;

  logic            push;
  logic [7:0]      fifo_rdata;
  logic            div_busy;
  logic [NUM_W-1:0] quo;

  logic [11:0] divv;
  logic [12:0] div13;
  logic [4:0]  presc;
  logic [3:0]  nbits;
  logic [5:0]  sdl;
  logic [TIME_W-1:0] cap;
  logic int_f, irq_now, tx_rdy, more;
  logic [7:0] sstat, pstat;
  logic [CW-1:0] count_dec;

  assign divv  = {pb[1][3:0], pb[0]};
  assign div13 = (divv == '0) ? 13'd4096 : {1'b0, divv};
  assign presc = (pb[7][3:0] == '0) ? 5'd16 : {1'b0, pb[7][3:0]};
  assign nbits = 4'd7 + {2'b0, smode[3:2]} + {3'b0, smode[4]} + {3'b0, pb[5][0]};
  assign sdl   = {1'b0, pb[2][4:0]} + 6'd2;
  assign cap   = (|ctime[TIME_W-1:TIME_W-6]) ? MAX48 : {ctime[TIME_W-7:0], 6'b0};
  assign more  = (accum >= ctime) && (nchar < MAX_CHARS);
  assign count_dec = count - CW'(1);

  // products at full width
  assign prod1 = mode_char ? div13 * presc : sdl * presc;
  assign prod2 = mode_char ? ma * nbits : {3'b0, ma};
  assign prod3 = tstate_hz * mb;

  assign int_f = !cf[CF_IM1] && ((pb[6][0] && cf[CF_INTP0]) || (pb[6][1] && cf[CF_INTP1]));
  assign irq_now = (cf[CF_TXEN] && cf[CF_TXRDY] && !smode[1]) ||
                   (cf[CF_RXEN] && ((!smode[7] && (ef[EF_RXRDY] || ef[EF_BRK])) ||
                    (!smode[6] && (ef[EF_FE] || ef[EF_OE] || ef[EF_PE])))) ||
                   int_f;
  assign tx_rdy = smode[1] ? cf[CF_TXRDY] : (cf[CF_TXRDY] && cf[CF_TXEN]);
  assign sstat = {1'b0, ef[EF_BRK], ef[EF_FE], ef[EF_OE], ef[EF_PE], cf[CF_TXEMP],
                  ef[EF_RXRDY], tx_rdy};
  assign pstat = {int_f, cf[CF_XBUSY] && !item.sub_acked, item.sub_busy, cf[CF_PRIM],
                  1'b1, plines[1], plines[2], !plines[0]};

  assign push = cmd.exec && item.func == FUNC_WRITE && item.reg_addr == REG_SDATA &&
                !cf[CF_HELD] && link && count < CW'(DEPTH);

  spio_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (item.write_data),
    .raddr (rd_ptr),
    .rdata (fifo_rdata)
  );

  spio_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (mp),
    .den   (xclk_hz),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign stat.func       = item.func;
  assign stat.reg_addr   = item.reg_addr;
  assign stat.held       = cf[CF_HELD];
  assign stat.param_calc = (pptr == 3'd0) || (pptr == 3'd1) || (pptr == 3'd5) ||
                           (pptr == 3'd7);
  assign stat.link       = link;
  assign stat.ct_nonzero = (ctime != '0);
  assign stat.div_busy   = div_busy;
  assign stat.more       = more;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      link      <= 1'b0;
      tstate_hz <= HZ_W'(1228800);
      xclk_hz   <= HZ_W'(1228800);
      for (int i = 0; i < 8; i++) begin
        pb[i] <= '0;
      end
      pptr      <= '0;
      cf        <= '0;
      cf[CF_IM1]   <= 1'b1;
      cf[CF_IM2]   <= 1'b1;
      cf[CF_TXRDY] <= 1'b1;
      cf[CF_TXEMP] <= 1'b1;
      smode     <= '0;
      ef        <= '0;
      rlatch    <= 8'hFF;
      pout      <= '0;
      plines    <= '0;
      count     <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      accum     <= '0;
      ctime     <= '0;
      nchar     <= '0;
      out_valid <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // configuration writes must come only while idle; the block does not enforce it
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LINK: begin
            link <= cfg_data[0];
            if (!cfg_data[0]) begin
              count  <= '0;
              wr_ptr <= '0;
              rd_ptr <= '0;
              accum  <= '0;
              cf[CF_TXRDY] <= 1'b1;
              cf[CF_TXEMP] <= 1'b1;
              plines <= '0;
            end
          end
          CFG_TSTATE: tstate_hz <= cfg_data;
          CFG_XCLK:   xclk_hz <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.capture) begin
        item <= in_data;
      end

      if (cmd.exec) begin
        rd_q     <= '0;
        strobe_q <= 1'b0;
        case (item.func)
          FUNC_READ: begin
            case (item.reg_addr)
              REG_SDATA: begin
                ef[EF_RXRDY] <= 1'b0;
                rd_q <= rlatch;
              end
              REG_PDATA: rd_q <= 8'hFF;
              REG_STAT:  rd_q <= sstat;
              default:   rd_q <= pstat;
            endcase
          end
          FUNC_WRITE: begin
            if (item.reg_addr == REG_CTRL) begin
              if (!item.write_data[7]) begin
                if (!cf[CF_HELD]) begin
                  cf[CF_TXEN] <= item.write_data[0];
                  cf[CF_DTR]  <= item.write_data[1];
                  cf[CF_RXEN] <= item.write_data[2];
                  cf[CF_SBRK] <= item.write_data[3];
                  cf[CF_RTS]  <= item.write_data[5];
                  if (item.write_data[4]) begin
                    ef <= ef & (5'b1 << EF_RXRDY);
                  end
                end
              end else if (!item.write_data[6]) begin
                if (!cf[CF_HELD]) begin
                  cf[CF_IM1]   <= item.write_data[5];
                  cf[CF_IM2]   <= item.write_data[4];
                  cf[CF_INTP0] <= 1'b0;
                  cf[CF_INTP1] <= 1'b0;
                  case (item.write_data[2:0])
                    PCMD_PRIM_SET: cf[CF_PRIM] <= 1'b1;
                    PCMD_PRIM_CLR: cf[CF_PRIM] <= 1'b0;
                    PCMD_XBUSY_CLR: begin
                      cf[CF_PRIM]  <= 1'b0;
                      cf[CF_XBUSY] <= 1'b0;
                    end
                    default: ;
                  endcase
                end
              end else begin
                pptr <= item.write_data[2:0];
                if (item.write_data[5]) begin
                  // chip reset, then hold until released
                  cf <= '0;
                  cf[CF_IM1]   <= 1'b1;
                  cf[CF_IM2]   <= 1'b1;
                  cf[CF_TXRDY] <= 1'b1;
                  cf[CF_TXEMP] <= 1'b1;
                  cf[CF_LBUSY] <= item.sub_busy;
                  cf[CF_HELD]  <= 1'b1;
                  ef     <= '0;
                  rlatch <= 8'hFF;
                  pout   <= '0;
                  count  <= '0;
                  wr_ptr <= '0;
                  rd_ptr <= '0;
                  accum  <= '0;
                end else begin
                  cf[CF_HELD] <= 1'b0;
                end
              end
            end else if (!cf[CF_HELD]) begin
              case (item.reg_addr)
                REG_SDATA: begin
                  if (!link) begin
                    cf[CF_TXRDY] <= 1'b1;
                    cf[CF_TXEMP] <= 1'b1;
                  end else begin
                    cf[CF_TXEMP] <= 1'b0;
                    if (count < CW'(DEPTH)) begin
                      count  <= count + CW'(1);
                      wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
                      cf[CF_TXRDY] <= (count + CW'(1)) < CW'(DEPTH);
                    end else begin
                      cf[CF_TXRDY] <= 1'b0;
                    end
                  end
                end
                REG_PDATA: begin
                  pout         <= item.write_data;
                  cf[CF_XBUSY] <= 1'b1;
                  cf[CF_INTP0] <= 1'b0;
                  cf[CF_INTP1] <= 1'b0;
                  cf[CF_LBUSY] <= item.sub_busy;
                  strobe_q     <= 1'b1;
                  mode_char    <= 1'b0;
                end
                default: begin
                  pb[pptr]  <= item.write_data;
                  mode_char <= 1'b1;
                  if (pptr == 3'd5) begin
                    smode <= item.write_data;
                  end
                end
              endcase
            end
          end
          FUNC_TICK: begin
            if (cf[CF_XBUSY] && item.sub_acked) begin
              cf[CF_XBUSY] <= 1'b0;
              cf[CF_INTP0] <= 1'b1;
            end
            if (cf[CF_LBUSY] && !item.sub_busy) begin
              cf[CF_INTP1] <= 1'b1;
            end
            cf[CF_LBUSY] <= item.sub_busy;
            if (link) begin
              plines <= {item.peer_ri, item.peer_dcd, item.peer_dsr, item.peer_cts};
            end
          end
          default: ;
        endcase
      end

      // timing math: factor, factor, clock, then divide
      if (cmd.mul1) begin
        ma <= prod1;
      end
      if (cmd.mul2) begin
        mb <= prod2;
      end
      if (cmd.mul3) begin
        mp <= mode_char ? {prod3, 3'b0} : {3'b0, prod3};
      end
      if (cmd.div_commit) begin
        if (mode_char) begin
          if (divv == 12'd1) begin
            ctime <= '0;
          end else if (quo[NUM_W-1]) begin
            ctime <= MAX48;
          end else if (quo == '0) begin
            ctime <= TIME_W'(1);
          end else begin
            ctime <= quo[TIME_W-1:0];
          end
        end else begin
          sdelay <= (|quo[NUM_W-1:16]) ? 16'hFFFF : quo[15:0];
        end
      end

      if (cmd.tick_add) begin
        sum <= {1'b0, accum} + (TIME_W + 1)'(item.elapsed_tstates);
      end
      if (cmd.tick_cap) begin
        accum <= (sum > {1'b0, cap}) ? cap : sum[TIME_W-1:0];
        nchar <= '0;
      end

      if (cmd.iter) begin
        accum    <= accum - ctime;
        nchar    <= nchar + 7'd1;
        it_taken <= 1'b0;
        it_txv   <= 1'b0;
        it_txb   <= '0;
        if (cf[CF_RXEN] && nchar == '0 && item.rx_offered) begin
          it_taken <= 1'b1;
          if (ef[EF_RXRDY]) begin
            ef[EF_OE] <= 1'b1;
          end else begin
            rlatch <= item.rx_byte;
            ef[EF_RXRDY] <= 1'b1;
          end
        end
        if (count != '0 && cf[CF_TXEN]) begin
          it_txv <= 1'b1;
          it_txb <= fifo_rdata;
          count  <= count_dec;
          rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
          cf[CF_TXRDY] <= 1'b1;
          if (count_dec == '0) begin
            cf[CF_TXEMP] <= 1'b1;
          end
        end
      end

      if (cmd.emit || cmd.emit_iter) begin
        out_valid <= 1'b1;
        out_data.irq       <= irq_now;
        out_data.dtr_line  <= cf[CF_DTR];
        out_data.rts_line  <= cf[CF_RTS];
        out_data.ring_line <= plines[3];
        if (cmd.emit) begin
          out_data.read_data    <= rd_q;
          out_data.strobe_valid <= strobe_q;
          out_data.strobe_byte  <= strobe_q ? ~pout : 8'h00;
          out_data.strobe_delay <= strobe_q ? sdelay : 16'h0000;
          out_data.tx_valid     <= 1'b0;
          out_data.tx_byte      <= '0;
          out_data.rx_taken     <= 1'b0;
          out_data.last         <= 1'b1;
        end else begin
          out_data.read_data    <= '0;
          out_data.strobe_valid <= 1'b0;
          out_data.strobe_byte  <= '0;
          out_data.strobe_delay <= '0;
          out_data.tx_valid     <= it_txv;
          out_data.tx_byte      <= it_txb;
          out_data.rx_taken     <= it_taken;
          out_data.last         <= !more;
        end
      end
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo count over depth");
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_iter) |-> (!out_valid || out_ready))
    else $error("result overwritten");
  a_char_bound: assert property (@(posedge clk) disable iff (rst)
    nchar <= MAX_CHARS)
    else $error("too many character times");

endmodule

// ===== src/serial_parallel_io_controller.sv =====
// ----------------------------------------------------------------------------
// serial_parallel_io_controller
// Four-register serial/parallel I/O controller with command handshake port.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A register read, a control write, a serial
// data write, a write to a parameter byte without timing effect, any write
// while held or an item with an unknown function passes through capture,
// execute and the output register before the next item can be taken. A
// parallel data write and a write to parameter bytes 0, 1, 5 or 7 run the
// timing math first: three multiply steps and a 49-step restoring divider.
// A tick with no peer or a stopped character clock passes through the same
// steps; otherwise it adds the elapsed time, caps the accumulator and then
// runs a check and an output step per character time it consumes (up to 64
// results), or outputs one result when it consumes none, with at most one
// transmit FIFO read per character from the registered-read RAM.
// Configuration writes are taken in any cycle but must come while the block
// is idle. A result waits in the output register until taken; the sequencer
// holds until that register frees up. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module serial_parallel_io_controller #(
  parameter int TX_FIFO_DEPTH = spio_pkg::TX_FIFO_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  spio_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spio_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [spio_pkg::HZ_W-1:0] cfg_data
);
  import spio_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  spio_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spio_dp #(.DEPTH(TX_FIFO_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== tb/serial_parallel_io_controller_checker.sv =====
// ----------------------------------------------------------------------------
// serial_parallel_io_controller_checker
// Watches the item and result channels, predicts every result and compares.
// ----------------------------------------------------------------------------
// Tracks configuration writes and accepted items, keeps its own copy of the
// controller state, queues the results each item should cause and checks each
// accepted result against the oldest one, field by field.
// ----------------------------------------------------------------------------
module serial_parallel_io_controller_checker
  import spio_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [HZ_W-1:0]     cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam int FIFO_D = TX_FIFO_DEPTH_DEF;
  localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;

  out_item_t  want_q[$];

  logic        link;
  logic [25:0] ts_hz, xc_hz;
  logic [7:0]  pbytes[8];
  logic [2:0]  pptr;
  logic [15:0] cf;
  logic [7:0]  smode;
  logic [4:0]  ef;
  logic [7:0]  rx_latch;
  logic [7:0]  txq[$];
  logic [47:0] accum, ctime;
  logic [3:0]  lines;

  assign pending = want_q.size();

  function automatic logic [63:0] xdiv();
    return (xc_hz == 0) ? 64'd1 : 64'(xc_hz);
  endfunction

  function automatic logic [63:0] presc();
    return (pbytes[7][3:0] == 0) ? 64'd16 : 64'(pbytes[7][3:0]);
  endfunction

  function automatic void update_char_time();
    logic [63:0] dv, bits;
    logic [127:0] t;
    dv = {pbytes[1][3:0], pbytes[0]};
    if (dv == 1) begin
      ctime = 0;
      return;
    end
    if (dv == 0) dv = 4096;
    bits = 6 + smode[3:2] + smode[4] + (pbytes[5][0] ? 2 : 1);
    t = 128'(ts_hz) * 8 * dv * presc() * bits / xdiv();
    if (t < 1) t = 1;
    if (t > CAP48) t = CAP48;
    ctime = t[47:0];
  endfunction

  function automatic logic [15:0] strobe_delay_of();
    logic [127:0] d;
    d = 128'(pbytes[2][4:0] + 2) * presc() * ts_hz / xdiv();
    return (d > 16'hFFFF) ? 16'hFFFF : d[15:0];
  endfunction

  function automatic logic int_f();
    if (cf[CF_IM1]) return 0;
    return (pbytes[6][0] && cf[CF_INTP0]) || (pbytes[6][1] && cf[CF_INTP1]);
  endfunction

  function automatic logic irq_of();
    logic tx, rx;
    tx = cf[CF_TXEN] && cf[CF_TXRDY] && !smode[1];
    rx = cf[CF_RXEN] && ((!smode[7] && (ef[EF_RXRDY] || ef[EF_BRK])) ||
         (!smode[6] && (ef[EF_FE] || ef[EF_OE] || ef[EF_PE])));
    return tx || rx || int_f();
  endfunction

  function automatic out_item_t base_result(logic [7:0] rd);
    out_item_t o;
    o = '0;
    o.read_data = rd;
    o.irq = irq_of();
    o.dtr_line = cf[CF_DTR];
    o.rts_line = cf[CF_RTS];
    o.ring_line = lines[3];
    return o;
  endfunction

  function automatic void drain_fifo();
    txq.delete();
    accum = 0;
    cf[CF_TXRDY] = 1;
    cf[CF_TXEMP] = 1;
  endfunction

  function automatic void chip_reset(logic busy);
    cf = '0;
    cf[CF_IM1] = 1;
    cf[CF_IM2] = 1;
    cf[CF_LBUSY] = busy;
    ef = '0;
    rx_latch = 8'hFF;
    drain_fifo();
  endfunction

  function automatic void power_up();
    link = 0;
    ts_hz = 1228800;
    xc_hz = 1228800;
    foreach (pbytes[i]) pbytes[i] = 0;
    pptr = 0;
    smode = 0;
    ctime = 0;
    lines = 0;
    chip_reset(0);
  endfunction

  function automatic void control_write(logic [7:0] v, logic busy);
    logic held;
    held = cf[CF_HELD];
    if (!v[7]) begin
      if (held) return;
      cf[CF_TXEN] = v[0];
      cf[CF_DTR] = v[1];
      cf[CF_RXEN] = v[2];
      cf[CF_SBRK] = v[3];
      cf[CF_RTS] = v[5];
      if (v[4]) ef = ef & (5'd1 << EF_RXRDY);
      return;
    end
    if (!v[6]) begin
      if (held) return;
      cf[CF_IM1] = v[5];
      cf[CF_IM2] = v[4];
      cf[CF_INTP0] = 0;
      cf[CF_INTP1] = 0;
      case (v[2:0])
        PCMD_PRIM_SET: cf[CF_PRIM] = 1;
        PCMD_PRIM_CLR: cf[CF_PRIM] = 0;
        PCMD_XBUSY_CLR: begin
          cf[CF_PRIM] = 0;
          cf[CF_XBUSY] = 0;
        end
        default: ;
      endcase
      return;
    end
    pptr = v[2:0];
    if (v[5]) begin
      chip_reset(busy);
      cf[CF_HELD] = 1;
    end else begin
      cf[CF_HELD] = 0;
    end
  endfunction

  // Work out the results of one item and queue them.
  function automatic void predict_item(in_item_t it);
    out_item_t o;
    logic [7:0] rd;
    logic [47:0] cap;
    logic [63:0] sum;
    int n;
    rd = 0;
    n = 0;
    case (it.func)
      FUNC_READ: begin
        case (it.reg_addr)
          REG_SDATA: begin
            ef[EF_RXRDY] = 0;
            rd = rx_latch;
          end
          REG_PDATA: rd = 8'hFF;
          REG_STAT: begin
            rd[0] = smode[1] ? cf[CF_TXRDY] : (cf[CF_TXRDY] && cf[CF_TXEN]);
            rd[1] = ef[EF_RXRDY];
            rd[2] = cf[CF_TXEMP];
            rd[3] = ef[EF_PE];
            rd[4] = ef[EF_OE];
            rd[5] = ef[EF_FE];
            rd[6] = ef[EF_BRK];
          end
          default: begin
            rd = 8'h08;
            rd[0] = !lines[0];
            rd[1] = lines[2];
            rd[2] = lines[1];
            rd[4] = cf[CF_PRIM];
            rd[5] = it.sub_busy;
            rd[6] = cf[CF_XBUSY] && !it.sub_acked;
            rd[7] = int_f();
          end
        endcase
      end
      FUNC_WRITE: begin
        if (it.reg_addr == REG_CTRL) begin
          control_write(it.write_data, it.sub_busy);
        end else if (!cf[CF_HELD]) begin
          if (it.reg_addr == REG_SDATA) begin
            if (!link) begin
              cf[CF_TXRDY] = 1;
              cf[CF_TXEMP] = 1;
            end else begin
              if (txq.size() < FIFO_D) txq.insert(txq.size(), it.write_data);
              cf[CF_TXEMP] = 0;
              cf[CF_TXRDY] = txq.size() < FIFO_D;
            end
          end else if (it.reg_addr == REG_PDATA) begin
            cf[CF_XBUSY] = 1;
            cf[CF_INTP0] = 0;
            cf[CF_INTP1] = 0;
            cf[CF_LBUSY] = it.sub_busy;
            o = base_result(0);
            o.strobe_valid = 1;
            o.strobe_byte = ~it.write_data;
            o.strobe_delay = strobe_delay_of();
            o.last = 1;
            want_q.insert(want_q.size(), o);
            return;
          end else begin
            pbytes[pptr] = it.write_data;
            if (pptr == 5) smode = it.write_data;
            if (pptr inside {3'd0, 3'd1, 3'd5, 3'd7}) update_char_time();
          end
        end
      end
      FUNC_TICK: begin
        if (cf[CF_XBUSY] && it.sub_acked) begin
          cf[CF_XBUSY] = 0;
          cf[CF_INTP0] = 1;
        end
        if (cf[CF_LBUSY] && !it.sub_busy) cf[CF_INTP1] = 1;
        cf[CF_LBUSY] = it.sub_busy;
        if (link) begin
          lines = {it.peer_ri, it.peer_dcd, it.peer_dsr, it.peer_cts};
          if (ctime != 0) begin
            sum = 64'(ctime) * 64;
            cap = (sum > CAP48) ? CAP48 : sum[47:0];
            sum = 64'(accum) + it.elapsed_tstates;
            accum = (sum > cap) ? cap : sum[47:0];
            while (accum >= ctime && n < 64) begin
              accum -= ctime;
              o = '0;
              if (cf[CF_RXEN] && n == 0 && it.rx_offered) begin
                o.rx_taken = 1;
                if (ef[EF_RXRDY]) ef[EF_OE] = 1;
                else begin
                  rx_latch = it.rx_byte;
                  ef[EF_RXRDY] = 1;
                end
              end
              if (txq.size() > 0 && cf[CF_TXEN]) begin
                o.tx_valid = 1;
                o.tx_byte = txq[0];
                txq.delete(0);
                if (txq.size() == 0) begin
                  cf[CF_TXEMP] = 1;
                  cf[CF_TXRDY] = 1;
                end else cf[CF_TXRDY] = 1;
              end
              o = '{read_data: 0, irq: irq_of(), strobe_valid: 0, strobe_byte: 0,
                    strobe_delay: 0, tx_valid: o.tx_valid, tx_byte: o.tx_byte,
                    rx_taken: o.rx_taken, dtr_line: cf[CF_DTR], rts_line: cf[CF_RTS],
                    ring_line: lines[3], last: 0};
              want_q.insert(want_q.size(), o);
              n++;
            end
          end
        end
        if (n > 0) begin
          want_q[want_q.size()-1].last = 1;
          return;
        end
      end
      default: ;
    endcase
    o = base_result(rd);
    o.last = 1;
    want_q.insert(want_q.size(), o);
  endfunction

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      power_up();
      want_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINK: begin
            link = cfg_data[0];
            if (!link) begin
              drain_fifo();
              lines = 0;
            end
          end
          CFG_TSTATE: ts_hz = cfg_data;
          CFG_XCLK: xc_hz = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          w = want_q[0];
          want_q.delete(0);
          if (w !== out_data) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, w, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
  end

endmodule

// ===== tb/serial_parallel_io_controller_tb.sv =====
// ----------------------------------------------------------------------------
// serial_parallel_io_controller_tb
// Stimulus and verdict for the serial and parallel I/O controller.
// ----------------------------------------------------------------------------
// Drives a directed pass through every register and special case, then
// random register traffic and ticks under several configurations and idling
// phases. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module serial_parallel_io_controller_tb;
  import spio_pkg::*;

  // function code with no meaning to the block
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

  logic            clk;
  logic            rst;
  logic            in_valid, in_ready;
  in_item_t        in_data;
  logic            out_valid, out_ready;
  out_item_t       out_data;
  logic            cfg_valid, cfg_ready;
  logic [1:0]      cfg_index;
  logic [HZ_W-1:0] cfg_data;
  int              errors, pending;
  int              send_idle_pct, recv_stall_pct;

  serial_parallel_io_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  serial_parallel_io_controller_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result side at random, changing only on falling edges.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drop one item on the channel, hold it until taken, then drop valid.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [HZ_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait out every expected result, then let the block idle.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic in_item_t rand_lines(in_item_t it);
    it.elapsed_tstates = 16'($urandom);
    it.sub_busy = 1'($urandom);
    it.sub_acked = 1'($urandom);
    {it.peer_cts, it.peer_dsr, it.peer_dcd, it.peer_ri} = 4'($urandom);
    it.rx_offered = 1'($urandom);
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk(logic [1:0] f, logic [1:0] r, logic [7:0] d);
    in_item_t it;
    it = rand_lines('0);
    it.func = f;
    it.reg_addr = r;
    it.write_data = d;
    return it;
  endfunction

  // Point at a parameter byte and write it.
  task automatic set_param(logic [2:0] idx, logic [7:0] v);
    send_item(mk(FUNC_WRITE, REG_CTRL, {5'b11000, idx}));
    send_item(mk(FUNC_WRITE, REG_STAT, v));
  endtask

  // Random item, mostly well-formed traffic: enable, fill FIFO, tick, read.
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) it = mk(FUNC_TICK, 2'($urandom), 8'($urandom));
    else if (pick < 50) it = mk(FUNC_WRITE, REG_SDATA, 8'($urandom));
    else if (pick < 68) it = mk(FUNC_READ, 2'($urandom), 8'($urandom));
    else if (pick < 80) it = mk(FUNC_WRITE, REG_CTRL, $urandom_range(1) ?
                                8'h27 : {1'b0, 7'($urandom)});
    else if (pick < 86) it = mk(FUNC_WRITE, REG_CTRL, 8'($urandom));
    else if (pick < 92) it = mk(FUNC_WRITE, REG_PDATA, 8'($urandom));
    else if (pick < 97) it = mk(FUNC_WRITE, REG_STAT, 8'($urandom));
    else it = mk(FUNC_UNKNOWN, 2'($urandom), 8'($urandom));
    if (it.func == FUNC_TICK && $urandom_range(3) == 0)
      it.elapsed_tstates = 16'($urandom_range(600));
    return it;
  endfunction

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      send_item(rand_item());
      // Release any hold so most traffic reaches deep state.
      if ($urandom_range(19) == 0) send_item(mk(FUNC_WRITE, REG_CTRL, 8'hC0));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: no peer, reads of every register, unknown function, a serial write and a tick.
    send_item(mk(FUNC_READ, REG_SDATA, 8'h00));
    send_item(mk(FUNC_READ, REG_PDATA, 8'h00));
    send_item(mk(FUNC_READ, REG_STAT, 8'h00));
    send_item(mk(FUNC_READ, REG_CTRL, 8'h00));
    send_item(mk(FUNC_UNKNOWN, REG_CTRL, 8'hFF));
    send_item(mk(FUNC_WRITE, REG_SDATA, 8'hA5));
    send_item(mk(FUNC_TICK, REG_SDATA, 8'h00));
    // Held in reset: writes ignored until the hold drops.
    send_item(mk(FUNC_WRITE, REG_CTRL, 8'hE0));
    send_item(mk(FUNC_WRITE, REG_CTRL, 8'h3F));
    send_item(mk(FUNC_WRITE, REG_PDATA, 8'h00));
    send_item(mk(FUNC_WRITE, REG_CTRL, 8'hC0));
    send_item(mk(FUNC_WRITE, REG_PDATA, 8'hFF));
    send_item(mk(FUNC_WRITE, REG_CTRL, 8'h9C));
    settle();

    write_cfg(CFG_LINK, 26'd1);
    write_cfg(CFG_TSTATE, 26'd1);
    write_cfg(CFG_XCLK, 26'd50000000);
    // Divisor one stops the character clock, then divisor 4096 and the smallest prescaler.
    set_param(3'd0, 8'h01);
    send_item(mk(FUNC_WRITE, REG_CTRL, 8'h27));
    send_item(mk(FUNC_TICK, REG_SDATA, 8'h00));
    set_param(3'd0, 8'h00);
    set_param(3'd7, 8'h01);
    set_param(3'd2, 8'h1F);
    set_param(3'd6, 8'h03);
    // Full FIFO drops bytes; a big tick then empties it.
    repeat (17) send_item(mk(FUNC_WRITE, REG_SDATA, 8'($urandom)));
    send_item(mk(FUNC_TICK, REG_SDATA, 8'h00));
    send_item('{func: FUNC_TICK, reg_addr: REG_SDATA, write_data: 8'h00,
                elapsed_tstates: 16'hFFFF, sub_busy: 1'b1, sub_acked: 1'b1,
                peer_cts: 1'b1, peer_dsr: 1'b1, peer_dcd: 1'b1, peer_ri: 1'b1,
                rx_offered: 1'b1, rx_byte: 8'hFF});
    settle();

    // Random phases across configurations, extremes included.
    write_cfg(CFG_TSTATE, 26'd1228800);
    write_cfg(CFG_XCLK, 26'd1228800);
    set_param(3'd0, 8'h02);
    set_param(3'd7, 8'h01);
    set_param(3'd5, 8'h00);
    run_phase(0, 0, 120);
    settle();

    write_cfg(CFG_TSTATE, 26'd50000000);
    write_cfg(CFG_XCLK, 26'd1);
    run_phase(82, 0, 90);
    settle();

    write_cfg(CFG_TSTATE, 26'd1000);
    write_cfg(CFG_XCLK, 26'd50000000);
    set_param(3'd5, 8'hFF);
    run_phase(0, 82, 100);
    settle();

    write_cfg(CFG_TSTATE, 26'd3000000);
    write_cfg(CFG_XCLK, 26'd2000000);
    run_phase(13, 13, 100);
    settle();

    write_cfg(CFG_LINK, 26'd0);
    run_phase(0, 0, 20);
    settle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spio_pkg.sv
src/spio_ram.sv
src/spio_div.sv
src/spio_ctrl.sv
src/spio_dp.sv
src/serial_parallel_io_controller.sv
tb/serial_parallel_io_controller_checker.sv
tb/serial_parallel_io_controller_tb.sv
